FILE: src/sha1s_pkg.sv
// Shared types and constants of the SHA-1 byte stream hasher.
package sha1s_pkg;

  localparam int CHAIN_WORDS = 5;
  localparam int BLOCK_WORDS = 16;
  localparam int CHAIN_AW    = $clog2(CHAIN_WORDS);
  localparam int BLOCK_AW    = $clog2(BLOCK_WORDS);
  localparam int ROUNDS      = 80;

  localparam logic CMD_DATA   = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_TOO_LONG     = 2'd1;
  localparam logic [1:0] STATUS_AFTER_FINISH = 2'd2;

  localparam logic [31:0] INIT_CHAIN [CHAIN_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] ROUND_K [4] = '{
    32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_PAD,
    S_CLOAD,
    S_ROUND,
    S_CSTORE,
    S_READOUT
  } sha1s_state_t;

endpackage

FILE: src/sha1s_ifs.sv
// Valid/ready channel interfaces for the hasher's request and result items.
interface sha1s_req_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] byte_value;

  modport source (output valid, output cmd, output byte_value, input ready);
  modport sink (input valid, input cmd, input byte_value, output ready);
endinterface

interface sha1s_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic [31:0] digest_word4;
  logic [1:0]  status;

  modport source (
    output valid, output digest_word0, output digest_word1, output digest_word2,
    output digest_word3, output digest_word4, output status, input ready
  );
  modport sink (
    input valid, input digest_word0, input digest_word1, input digest_word2,
    input digest_word3, input digest_word4, input status, output ready
  );
endinterface

FILE: src/sha1s_ram.sv
// Generic single-write, single-read memory with a registered read port.
module sha1s_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/sha1_byte_stream_hasher.sv
// Top level of the SHA-1 byte stream hasher: sequencer, round datapath and memories.
//
// Usage. Items arrive on the req channel (valid/ready). An item with cmd at
// data appends byte_value to the message; an item with cmd at finish pads the
// message, completes the hash and returns one result item on the rsp channel
// holding the 160-bit digest (digest_word0 most significant) and a status.
// Later finish items return the same digest again. Data bytes produce no result.
// Data bytes are accepted while the sequencer is idle. The 64th byte of a block
// starts a compression (reading the chaining words from their memory, 80
// rounds, then read-add-write back), during which no item is accepted.
// A first finish item costs up to 18 padding writes, one or two compressions
// and a digest read before the result item is offered; a repeated finish
// costs only the digest read. An error status (length overflow, or data after
// finish) is sticky until reset; finish then answers at once with a zero digest.
// Reset: rst is synchronous; after it, the initial chaining words are loaded
// into memory, during which no item is accepted.
// Stalls: while a result item waits on rsp, data bytes are still accepted,
// but a further finish item is held off until the result has been taken.
module sha1_byte_stream_hasher
  import sha1s_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  sha1s_req_if.sink   req,
  sha1s_rsp_if.source rsp
);

  // Sequencer and message bookkeeping.
  sha1s_state_t state, state_next;
  logic [6:0]   cnt, cnt_next;
  logic [5:0]   fill_count, fill_count_next;
  logic [63:0]  bit_count, bit_count_next;
  logic         finished, finished_next;
  logic [1:0]   error_code, error_code_next;
  logic [23:0]  word_acc, word_acc_next;
  logic [4:0]   widx, widx_next;
  logic         in_pad, in_pad_next;
  logic         pad_last, pad_last_next;

  // Round datapath: working variables and the 16-word schedule window.
  logic [31:0] hash_a, hash_b, hash_c, hash_d, hash_e;
  logic [31:0] hash_a_next, hash_b_next, hash_c_next, hash_d_next, hash_e_next;
  logic [31:0] sched [BLOCK_WORDS];
  logic [31:0] sched_next [BLOCK_WORDS];

  // Result register.
  logic        rsp_valid, rsp_valid_next;
  logic [31:0] dig [CHAIN_WORDS];
  logic [31:0] dig_next [CHAIN_WORDS];
  logic [1:0]  status, status_next;

  // Memory ports.
  logic                chain_we;
  logic [CHAIN_AW-1:0] chain_waddr, chain_raddr;
  logic [31:0]         chain_wdata, chain_rdata;
  logic                blk_we;
  logic [BLOCK_AW-1:0] blk_waddr, blk_raddr;
  logic [31:0]         blk_wdata, blk_rdata;

  logic        req_ready;
  logic [63:0] count_sum;
  logic [31:0] pad_word;
  logic [31:0] w_cur;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;
  logic [6:0]  cnt_inc;

  sha1s_ram #(.WIDTH(32), .DEPTH(CHAIN_WORDS)) u_chain_ram (
    .clk   (clk),
    .we    (chain_we),
    .waddr (chain_waddr),
    .wdata (chain_wdata),
    .raddr (chain_raddr),
    .rdata (chain_rdata)
  );

  sha1s_ram #(.WIDTH(32), .DEPTH(BLOCK_WORDS)) u_block_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .raddr (blk_raddr),
    .rdata (blk_rdata)
  );

  // A finish item needs the result register free; data items do not.
  assign req_ready = (state == S_IDLE) && ((req.cmd == CMD_DATA) || !rsp_valid);
  assign req.ready = req_ready;

  assign rsp.valid        = rsp_valid;
  assign rsp.digest_word0 = dig[0];
  assign rsp.digest_word1 = dig[1];
  assign rsp.digest_word2 = dig[2];
  assign rsp.digest_word3 = dig[3];
  assign rsp.digest_word4 = dig[4];
  assign rsp.status       = status;

  assign count_sum = bit_count + 64'd8;
  assign cnt_inc   = cnt + 7'd1;

  // Word holding the pending bytes of the current word, the 0x80 marker and zeros.
  always_comb begin
    case (fill_count[1:0])
      2'd0:    pad_word = {PAD_BYTE, 24'h0};
      2'd1:    pad_word = {word_acc[7:0], PAD_BYTE, 16'h0};
      2'd2:    pad_word = {word_acc[15:0], PAD_BYTE, 8'h0};
      default: pad_word = {word_acc[23:0], PAD_BYTE};
    endcase
  end

  // Round function. The first 16 words come straight from the block memory.
  always_comb begin
    if (cnt < 7'd16) begin
      w_cur = blk_rdata;
    end else begin
      w_cur = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
      w_cur = {w_cur[30:0], w_cur[31]};
    end
    if (cnt < 7'd20) begin
      f_val = (hash_b & hash_c) | (~hash_b & hash_d);
      k_val = ROUND_K[0];
    end else if (cnt < 7'd40) begin
      f_val = hash_b ^ hash_c ^ hash_d;
      k_val = ROUND_K[1];
    end else if (cnt < 7'd60) begin
      f_val = (hash_b & hash_c) | (hash_b & hash_d) | (hash_c & hash_d);
      k_val = ROUND_K[2];
    end else begin
      f_val = hash_b ^ hash_c ^ hash_d;
      k_val = ROUND_K[3];
    end
    t_val = {hash_a[26:0], hash_a[31:27]} + f_val + hash_e + w_cur + k_val;
  end

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    fill_count_next = fill_count;
    bit_count_next  = bit_count;
    finished_next   = finished;
    error_code_next = error_code;
    word_acc_next   = word_acc;
    widx_next       = widx;
    in_pad_next     = in_pad;
    pad_last_next   = pad_last;
    hash_a_next     = hash_a;
    hash_b_next     = hash_b;
    hash_c_next     = hash_c;
    hash_d_next     = hash_d;
    hash_e_next     = hash_e;
    sched_next      = sched;
    dig_next        = dig;
    status_next     = status;
    rsp_valid_next  = rsp_valid && !rsp.ready;

    chain_we    = 1'b0;
    chain_waddr = '0;
    chain_wdata = '0;
    chain_raddr = '0;
    blk_we      = 1'b0;
    blk_waddr   = '0;
    blk_wdata   = '0;
    blk_raddr   = '0;

    unique case (state)
      S_INIT: begin
        chain_we    = 1'b1;
        chain_waddr = cnt[CHAIN_AW-1:0];
        chain_wdata = INIT_CHAIN[cnt[CHAIN_AW-1:0]];
        if (cnt == 7'(CHAIN_WORDS - 1)) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt_inc;
        end
      end

      S_IDLE: begin
        if (req.valid && req_ready) begin
          if (req.cmd == CMD_DATA) begin
            if (finished) begin
              error_code_next = STATUS_AFTER_FINISH;
            end else if (error_code == STATUS_OK) begin
              bit_count_next = count_sum;
              if (count_sum == 64'd0) begin
                error_code_next = STATUS_TOO_LONG;
              end
              if (fill_count[1:0] == 2'd3) begin
                blk_we    = 1'b1;
                blk_waddr = fill_count[5:2];
                blk_wdata = {word_acc, req.byte_value};
              end else begin
                word_acc_next = {word_acc[15:0], req.byte_value};
              end
              fill_count_next = fill_count + 6'd1;
              if (fill_count == 6'd63) begin
                in_pad_next = 1'b0;
                cnt_next    = '0;
                state_next  = S_CLOAD;
              end
            end
          end else begin
            if (error_code != STATUS_OK) begin
              rsp_valid_next = 1'b1;
              for (int i = 0; i < CHAIN_WORDS; i++) begin
                dig_next[i] = '0;
              end
              status_next = error_code;
            end else if (finished) begin
              cnt_next   = '0;
              state_next = S_READOUT;
            end else begin
              blk_we        = 1'b1;
              blk_waddr     = fill_count[5:2];
              blk_wdata     = pad_word;
              widx_next     = {1'b0, fill_count[5:2]} + 5'd1;
              // At 56 or more pending bytes the length spills into a second block.
              pad_last_next = (fill_count[5:3] != 3'b111);
              in_pad_next   = 1'b1;
              state_next    = S_PAD;
            end
          end
        end
      end

      S_PAD: begin
        if (widx[4]) begin
          cnt_next   = '0;
          state_next = S_CLOAD;
        end else begin
          blk_we    = 1'b1;
          blk_waddr = widx[3:0];
          if (pad_last && widx[3:0] == 4'd14) begin
            blk_wdata = bit_count[63:32];
          end else if (pad_last && widx[3:0] == 4'd15) begin
            blk_wdata = bit_count[31:0];
          end else begin
            blk_wdata = '0;
          end
          widx_next = widx + 5'd1;
          if (pad_last && widx[3:0] == 4'd15) begin
            cnt_next   = '0;
            state_next = S_CLOAD;
          end
        end
      end

      S_CLOAD: begin
        if (cnt < 7'(CHAIN_WORDS)) begin
          chain_raddr = cnt[CHAIN_AW-1:0];
        end
        if (cnt != 7'd0) begin
          hash_a_next = hash_b;
          hash_b_next = hash_c;
          hash_c_next = hash_d;
          hash_d_next = hash_e;
          hash_e_next = chain_rdata;
        end
        if (cnt == 7'(CHAIN_WORDS)) begin
          blk_raddr  = '0;
          cnt_next   = '0;
          state_next = S_ROUND;
        end else begin
          cnt_next = cnt_inc;
        end
      end

      S_ROUND: begin
        blk_raddr   = cnt_inc[BLOCK_AW-1:0];
        hash_e_next = hash_d;
        hash_d_next = hash_c;
        hash_c_next = {hash_b[1:0], hash_b[31:2]};
        hash_b_next = hash_a;
        hash_a_next = t_val;
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          sched_next[i] = sched[i+1];
        end
        sched_next[BLOCK_WORDS-1] = w_cur;
        if (cnt == 7'(ROUNDS - 1)) begin
          cnt_next   = '0;
          state_next = S_CSTORE;
        end else begin
          cnt_next = cnt_inc;
        end
      end

      S_CSTORE: begin
        // Read each chaining word and add its working variable in the next cycle.
        if (cnt < 7'(CHAIN_WORDS)) begin
          chain_raddr = cnt[CHAIN_AW-1:0];
        end
        if (cnt != 7'd0) begin
          chain_we    = 1'b1;
          chain_waddr = CHAIN_AW'(cnt - 7'd1);
          chain_wdata = chain_rdata + hash_a;
          hash_a_next = hash_b;
          hash_b_next = hash_c;
          hash_c_next = hash_d;
          hash_d_next = hash_e;
        end
        if (cnt == 7'(CHAIN_WORDS)) begin
          cnt_next        = '0;
          fill_count_next = '0;
          if (!in_pad) begin
            state_next = S_IDLE;
          end else if (pad_last) begin
            finished_next = 1'b1;
            state_next    = S_READOUT;
          end else begin
            widx_next     = '0;
            pad_last_next = 1'b1;
            state_next    = S_PAD;
          end
        end else begin
          cnt_next = cnt_inc;
        end
      end

      S_READOUT: begin
        if (cnt < 7'(CHAIN_WORDS)) begin
          chain_raddr = cnt[CHAIN_AW-1:0];
        end
        if (cnt != 7'd0) begin
          for (int i = 0; i < CHAIN_WORDS - 1; i++) begin
            dig_next[i] = dig[i+1];
          end
          dig_next[CHAIN_WORDS-1] = chain_rdata;
        end
        if (cnt == 7'(CHAIN_WORDS)) begin
          rsp_valid_next = 1'b1;
          status_next    = STATUS_OK;
          cnt_next       = '0;
          state_next     = S_IDLE;
        end else begin
          cnt_next = cnt_inc;
        end
      end

      default: begin
        cnt_next   = '0;
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      cnt        <= '0;
      fill_count <= '0;
      bit_count  <= '0;
      finished   <= 1'b0;
      error_code <= STATUS_OK;
      in_pad     <= 1'b0;
      pad_last   <= 1'b0;
      widx       <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      fill_count <= fill_count_next;
      bit_count  <= bit_count_next;
      finished   <= finished_next;
      error_code <= error_code_next;
      in_pad     <= in_pad_next;
      pad_last   <= pad_last_next;
      widx       <= widx_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    word_acc <= word_acc_next;
    hash_a   <= hash_a_next;
    hash_b   <= hash_b_next;
    hash_c   <= hash_c_next;
    hash_d   <= hash_d_next;
    hash_e   <= hash_e_next;
    sched    <= sched_next;
    dig      <= dig_next;
    status   <= status_next;
  end

endmodule

FILE: bench/tb.sv
// Self-checking bench for the SHA-1 byte stream hasher over valid/ready channels.
module tb
  import sha1s_pkg::*;
();

  localparam int N_ITEMS     = 1600;          // stimulus target, directed rows included
  localparam int PHASE_LEN   = N_ITEMS / 3;   // items per pacing phase
  localparam int QUIET_LIMIT = 2000;          // cycles with no handshake before giving up
  localparam int TAIL_CYCLES = 64;            // settle time once nothing is outstanding
  localparam int N_LEAD      = 12;            // rows played before the random message body
  localparam int N_ROWS      = 18;

  typedef struct packed {
    logic [4:0][31:0] words;  // words[0] is the most significant digest word
    logic [1:0]       status;
  } digest_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       typed;  // when set, want is the expected reply in place of the predictor's
    digest_t    want;
  } stim_row_t;

  localparam digest_t LATE_DATA_REPLY = '{words: '0, status: STATUS_AFTER_FINISH};

  // The first N_LEAD rows open the message with edge and pattern byte values. The rest
  // run once the message is sealed: data after finish latches the sticky error,
  // and every finish from then on answers with a zero digest.
  stim_row_t rows [N_ROWS] = '{
    '{CMD_DATA,   8'h00, 1'b0, '0},
    '{CMD_DATA,   8'hFF, 1'b0, '0},
    '{CMD_DATA,   8'h80, 1'b0, '0},
    '{CMD_DATA,   8'h01, 1'b0, '0},
    '{CMD_DATA,   8'h7F, 1'b0, '0},
    '{CMD_DATA,   8'hFE, 1'b0, '0},
    '{CMD_DATA,   8'h55, 1'b0, '0},
    '{CMD_DATA,   8'hAA, 1'b0, '0},
    '{CMD_DATA,   8'h0F, 1'b0, '0},
    '{CMD_DATA,   8'hF0, 1'b0, '0},
    '{CMD_DATA,   8'h36, 1'b0, '0},
    '{CMD_DATA,   8'h5C, 1'b0, '0},
    '{CMD_DATA,   8'h00, 1'b0, '0},
    '{CMD_FINISH, 8'h00, 1'b1, LATE_DATA_REPLY},
    '{CMD_DATA,   8'hFF, 1'b0, '0},
    '{CMD_FINISH, 8'hFF, 1'b1, LATE_DATA_REPLY},
    '{CMD_FINISH, 8'h00, 1'b1, LATE_DATA_REPLY},
    '{CMD_DATA,   8'h80, 1'b0, '0}
  };

  logic clk;
  logic rst;

  sha1s_req_if req_ch ();
  sha1s_rsp_if rsp_ch ();

  sha1_byte_stream_hasher dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Predictor state: chaining words, block buffer, length and status flags.
  logic [31:0] chain_h [5];
  logic [7:0]  msg_buf [64];
  int          buf_fill;
  logic [63:0] msg_bits;
  logic        sealed;
  logic [1:0]  sticky_err;

  digest_t digests_due [$];
  int      items_sent;
  int      fail_count;
  int      quiet;
  int      gap_pct;
  int      stall_pct;

  function automatic logic [31:0] rol32(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic sha_fold_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, t, k;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_buf[4*i], msg_buf[4*i+1], msg_buf[4*i+2], msg_buf[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = rol32(a, 5) + f + e + w[i] + k;
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
    buf_fill = 0;
  endtask

  // Padding: 0x80, zeros, then the 64-bit big-endian bit length. A second block
  // is needed when the marker byte leaves no room for the length field.
  task automatic sha_seal_message();
    int n;
    n = buf_fill;
    msg_buf[n] = 8'h80;
    n++;
    if (n > 56) begin
      while (n < 64) begin
        msg_buf[n] = 8'h00;
        n++;
      end
      sha_fold_block();
      n = 0;
    end
    while (n < 56) begin
      msg_buf[n] = 8'h00;
      n++;
    end
    for (int i = 0; i < 8; i++)
      msg_buf[56+i] = msg_bits[63-8*i -: 8];
    sha_fold_block();
  endtask

  // Applies one accepted item to the predicted state and returns its reply, if any.
  // The length overflow needs 2^61 bytes, so it is modeled but never reached here.
  task automatic hash_absorb(input logic cmd, input logic [7:0] data,
                             output bit has_reply, output digest_t reply);
    has_reply = 1'b0;
    reply = '0;
    if (cmd == CMD_DATA) begin
      if (sealed) begin
        sticky_err = STATUS_AFTER_FINISH;
      end else if (sticky_err == STATUS_OK) begin
        msg_buf[buf_fill] = data;
        buf_fill++;
        msg_bits += 64'd8;
        if (msg_bits == 64'd0)
          sticky_err = STATUS_TOO_LONG;
        if (buf_fill == 64)
          sha_fold_block();
      end
    end else begin
      has_reply = 1'b1;
      if (sticky_err != STATUS_OK) begin
        reply.status = sticky_err;
      end else begin
        if (!sealed) begin
          sha_seal_message();
          sealed = 1'b1;
        end
        for (int i = 0; i < 5; i++)
          reply.words[i] = chain_h[i];
        reply.status = STATUS_OK;
      end
    end
  endtask

  // Offers one item, with random idle cycles ahead of it, and waits for the handshake.
  task automatic send_item(input logic cmd, input logic [7:0] data,
                           input logic typed, input digest_t want);
    bit      has_reply;
    digest_t reply;
    if (items_sent < PHASE_LEN) begin
      gap_pct = 14;
      stall_pct = 50;
    end else if (items_sent < 2 * PHASE_LEN) begin
      gap_pct = 50;
      stall_pct = 14;
    end else begin
      gap_pct = 0;
      stall_pct = 0;
    end
    while ($urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= cmd;
    req_ch.byte_value <= data;
    @(posedge clk);
    while (req_ch.ready !== 1'b1)
      @(posedge clk);
    items_sent++;
    hash_absorb(cmd, data, has_reply, reply);
    if (has_reply)
      digests_due.push_back(typed ? want : reply);
  endtask

  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    while (digests_due.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result checker and receiver pacing. Outputs are sampled at the edge, before
  // the design's registers update, so process order within the step is irrelevant.
  always @(posedge clk) begin : rsp_check
    digest_t seen;
    digest_t due;
    if (rst) begin
      quiet <= 0;
    end else begin
      if ((req_ch.valid && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
        seen.words[0] = rsp_ch.digest_word0;
        seen.words[1] = rsp_ch.digest_word1;
        seen.words[2] = rsp_ch.digest_word2;
        seen.words[3] = rsp_ch.digest_word3;
        seen.words[4] = rsp_ch.digest_word4;
        seen.status   = rsp_ch.status;
        if (digests_due.size() == 0) begin
          $error("result item arrived with no finish item outstanding");
          fail_count++;
        end else begin
          due = digests_due.pop_front();
          for (int i = 0; i < 5; i++) begin
            if (seen.words[i] !== due.words[i]) begin
              $error("digest_word%0d: expected %08h, got %08h", i, due.words[i],
                     seen.words[i]);
              fail_count++;
            end
          end
          if (seen.status !== due.status) begin
            $error("status: expected %0d, got %0d", due.status, seen.status);
            fail_count++;
          end
        end
      end
    end
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    while (quiet < QUIET_LIMIT)
      @(posedge clk);
    $display("tb: errors");
    $finish;
  end

  initial begin
    int body;
    int rem;
    int reps;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_DATA;
    req_ch.byte_value = 8'h00;
    rsp_ch.ready = 1'b0;
    chain_h = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
    buf_fill = 0;
    msg_bits = '0;
    sealed = 1'b0;
    sticky_err = STATUS_OK;
    items_sent = 0;
    fail_count = 0;
    quiet = 0;
    gap_pct = 14;
    stall_pct = 50;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_LEAD; i++)
      send_item(rows[i].cmd, rows[i].data, rows[i].typed, rows[i].want);

    // One message per run, since the sticky error never clears. Its length is
    // biased toward the padding boundaries: an empty tail block, the longest tail
    // that still fits the length field, the shortest that spills into a second
    // block, and a nearly full block.
    case ($urandom_range(4))
      0: rem = 0;
      1: rem = 55;
      2: rem = 56;
      3: rem = 63;
      default: rem = $urandom_range(63);
    endcase
    body = 64 * $urandom_range(11, 15) + rem - N_LEAD;
    for (int i = 0; i < body; i++)
      send_item(CMD_DATA, 8'($urandom_range(255)), 1'b0, '0);

    // First finish seals the message; the repeats must return the same digest.
    reps = $urandom_range(30, 60);
    for (int i = 0; i < reps; i++)
      send_item(CMD_FINISH, 8'($urandom_range(255)), 1'b0, '0);

    // Let every digest come back before data arrives after the finish.
    hold_until_drained();

    for (int i = N_LEAD; i < N_ROWS; i++)
      send_item(rows[i].cmd, rows[i].data, rows[i].typed, rows[i].want);

    // Error state: dropped data mixed with finish items that report the fault.
    while (items_sent < N_ITEMS) begin
      if ($urandom_range(3) == 0)
        send_item(CMD_FINISH, 8'($urandom_range(255)), 1'b0, '0);
      else
        send_item(CMD_DATA, 8'($urandom_range(255)), 1'b0, '0);
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
